### hw/rtl/bresenham_line_stair_count_top_defines.svh
// Assertion macros used by the checker.
`ifndef BRESENHAM_LINE_STAIR_COUNT_TOP_DEFINES_SVH
`define BRESENHAM_LINE_STAIR_COUNT_TOP_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset
`define BLSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the default clock and reset names
`define BLSC_ASSERT_CLK(lbl, prop, msg) \
  `BLSC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/blsc_pkg.sv
package blsc_pkg;

  // Extra bits of the error term over the coordinate width (sign plus 2x headroom)
  localparam int ERR_GUARD_BITS = 3;

endpackage

### hw/rtl/blsc_if.sv
// Request channel: one line segment
interface blsc_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, output x_start, output y_start, output x_end,
                  output y_end, input ready);
  modport sink   (input valid, input x_start, input y_start, input x_end,
                  input y_end, output ready);
endinterface

// Result channel: stair count of one segment
interface blsc_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   stair_count;

  modport source (output valid, output stair_count, input ready);
  modport sink   (input valid, input stair_count, output ready);
endinterface

### hw/rtl/bresenham_line_stair_count_top.sv
// Channel  Dir  Payload                               Handshake
// in_i     in   x_start, y_start, x_end, y_end        valid/ready
// out_o    out  stair_count                           valid/ready
//
// A request is taken only while the sequencer is idle; absolute deltas are
// formed in that cycle, the next cycle orders them and seeds the error term.
// The error loop then runs major delta + 1 iterations, one per cycle; no new
// request is taken until the last iteration is done.
// A result waits in the output register; the last iteration holds while it
// is still occupied. Reset is asynchronous, active low, and clears control.
module bresenham_line_stair_count_top #(
  parameter int COORD_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  blsc_in_if.sink    in_i,
  blsc_out_if.source out_o
);
  import blsc_pkg::*;

  localparam int DW = COORD_BITS;
  localparam int CW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + ERR_GUARD_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  state_e               state_q;
  logic [DW-1:0]        major_q;
  logic [DW-1:0]        minor_q;
  logic signed [EW-1:0] err_q;
  logic [CW-1:0]        step_q;
  logic [CW-1:0]        stair_q;
  logic                 out_valid_q;
  logic [CW-1:0]        out_count_q;

  // Absolute deltas of the incoming request
  logic signed [DW:0] diff_x;
  logic signed [DW:0] diff_y;
  logic [DW:0]        abs_x;
  logic [DW:0]        abs_y;

  assign diff_x = $signed({in_i.x_end[DW-1], in_i.x_end})
                - $signed({in_i.x_start[DW-1], in_i.x_start});
  assign diff_y = $signed({in_i.y_end[DW-1], in_i.y_end})
                - $signed({in_i.y_start[DW-1], in_i.y_start});
  assign abs_x  = diff_x[DW] ? (~diff_x + 1'b1) : diff_x;
  assign abs_y  = diff_y[DW] ? (~diff_y + 1'b1) : diff_y;

  // Order the deltas and seed the error term
  logic                 swap;
  logic [DW-1:0]        major_sel;
  logic [DW-1:0]        minor_sel;
  logic signed [EW-1:0] err_init;

  assign swap      = minor_q > major_q;
  assign major_sel = swap ? minor_q : major_q;
  assign minor_sel = swap ? major_q : minor_q;
  assign err_init  = $signed({{(EW-DW-1){1'b0}}, minor_sel, 1'b0})
                   - $signed({{(EW-DW){1'b0}}, major_sel});

  // One error iteration: subtract on a stair, then add the minor step if negative
  logic signed [EW-1:0] two_major;
  logic signed [EW-1:0] two_minor;
  logic                 stair_hit;
  logic signed [EW-1:0] err_sub;
  logic signed [EW-1:0] err_d;
  logic [CW-1:0]        stair_d;
  logic                 last_step;
  logic                 advance;

  assign two_major = $signed({{(EW-DW-1){1'b0}}, major_q, 1'b0});
  assign two_minor = $signed({{(EW-DW-1){1'b0}}, minor_q, 1'b0});
  assign stair_hit = ~err_q[EW-1];
  assign err_sub   = stair_hit ? (err_q - two_major) : err_q;
  assign err_d     = err_sub[EW-1] ? (err_sub + two_minor) : err_sub;
  assign stair_d   = stair_q + CW'(stair_hit);
  assign last_step = step_q == {1'b0, major_q};
  assign advance   = ~last_step | ~out_valid_q | out_o.ready;

  assign in_i.ready        = state_q == ST_IDLE;
  assign out_o.valid       = out_valid_q;
  assign out_o.stair_count = out_count_q;

  // Hold payload registers without reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          major_q <= abs_x[DW-1:0];
          minor_q <= abs_y[DW-1:0];
        end
      end
      ST_SETUP: begin
        major_q <= major_sel;
        minor_q <= minor_sel;
        err_q   <= err_init;
        stair_q <= '0;
      end
      ST_RUN: begin
        if (advance) begin
          err_q   <= err_d;
          stair_q <= stair_d;
        end
      end
      default: begin
        err_q <= err_q;
      end
    endcase
    if (state_q == ST_RUN && advance && last_step) begin
      out_count_q <= stair_d;
    end
  end

  // Sequence the request and hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          step_q  <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (advance) begin
            step_q <= step_q + 1'b1;
            if (last_step) begin
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/blsc_checker.sv
`include "bresenham_line_stair_count_top_defines.svh"

module blsc_checker #(
  parameter int COORD_BITS = 12
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [COORD_BITS:0] stair_count
);

  // Longest possible line: one stair per pixel of a full-range diagonal
  localparam logic [COORD_BITS:0] CNT_MAX = {1'b1, {COORD_BITS{1'b0}}};

  // Result stays offered until taken
  `BLSC_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")

  // Stalled result keeps its value
  `BLSC_ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(stair_count), "result changed")

  // Busy right after a request is taken
  `BLSC_ASSERT_CLK(a_busy_after_req, in_valid && in_ready |=> !in_ready, "ready while busy")

  // No result can appear in the cycle after a request is taken
  `BLSC_ASSERT_CLK(a_no_early_result, in_valid && in_ready |=> !$rose(out_valid), "result too early")

  // Stair count never exceeds the longest possible line
  `BLSC_ASSERT_CLK(a_count_range, out_valid |-> stair_count <= CNT_MAX, "count out of range")

endmodule

bind bresenham_line_stair_count_top blsc_checker #(
  .COORD_BITS(COORD_BITS)
) u_blsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .stair_count(out_o.stair_count)
);
